FILE: hdl/rdc_pkg.sv
// shared types, constants and a helper function for the radix digit converter
`default_nettype none
package rdc_pkg;

  localparam int NUMBER_BITS = 31;
  localparam int MAX_DIGITS  = 31;
  localparam int BASE_W      = 5;
  localparam int DIG_W       = 4;
  localparam int CHAR_W      = 7;
  localparam int CYC_W       = $clog2(NUMBER_BITS + MAX_DIGITS);
  localparam int CNT_W       = $clog2(MAX_DIGITS + 1);

  localparam logic [BASE_W-1:0] BASE_MIN = BASE_W'(2);
  localparam logic [BASE_W-1:0] BASE_MAX = BASE_W'(16);
  localparam logic [DIG_W-1:0]  DEC_LIM  = DIG_W'(10);
  localparam logic [CHAR_W-1:0] CHAR_ZERO = CHAR_W'(8'h30);
  localparam logic [CHAR_W-1:0] CHAR_A    = CHAR_W'(8'h41);

  // last accumulate step lands in the top cell on this count
  localparam logic [CYC_W-1:0] CONV_DONE = CYC_W'(NUMBER_BITS + MAX_DIGITS - 2);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT,
    ST_INV
  } state_t;

  typedef struct packed {
    logic clear;
    logic feed;
    logic shift;
  } array_ctl_t;

  function automatic logic [CHAR_W-1:0] ascii_of(input logic [DIG_W-1:0] d);
    logic [CHAR_W-1:0] r;
    if (d < DEC_LIM) begin
      r = CHAR_ZERO + CHAR_W'(d);
    end else begin
      r = CHAR_A + CHAR_W'(d - DEC_LIM);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/rdc_cell.sv
// one digit cell: doubles its digit plus carry modulo the base, shifts for readout
`default_nettype none
module rdc_cell (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire rdc_pkg::array_ctl_t          ctl,
  input  wire logic [rdc_pkg::BASE_W-1:0]   base,
  input  wire logic                         tok_in,
  input  wire logic                         cin,
  input  wire logic [rdc_pkg::DIG_W-1:0]    dig_in,
  output logic                              tok_out_r,
  output logic                              cout_r,
  output logic [rdc_pkg::DIG_W-1:0]         digit_r
);

  logic [rdc_pkg::BASE_W-1:0] sum;
  logic [rdc_pkg::BASE_W-1:0] diff;
  logic                       ge;
  logic [rdc_pkg::DIG_W-1:0]  digit_nxt;
  logic                       tok_out_nxt;

  assign sum  = {digit_r, cin};
  assign ge   = (sum >= base);
  assign diff = sum - base;

  always_comb begin
    digit_nxt   = digit_r;
    tok_out_nxt = tok_in;
    if (ctl.clear) begin
      digit_nxt   = '0;
      tok_out_nxt = 1'b0;
    end else if (ctl.shift) begin
      digit_nxt = dig_in;
    end else if (tok_in) begin
      digit_nxt = ge ? diff[rdc_pkg::DIG_W-1:0] : sum[rdc_pkg::DIG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_out_r <= 1'b0;
    end else begin
      tok_out_r <= tok_out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
    cout_r  <= ge;
  end

endmodule
`default_nettype wire

FILE: hdl/rdc_digit_array.sv
// systolic row of digit cells, carries move one cell per cycle
`default_nettype none
module rdc_digit_array (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire rdc_pkg::array_ctl_t          ctl,
  input  wire logic [rdc_pkg::BASE_W-1:0]   base,
  input  wire logic                         feed_bit,
  output logic [rdc_pkg::DIG_W-1:0]         top_digit
);

  logic                      tok   [rdc_pkg::MAX_DIGITS];
  logic                      carry [rdc_pkg::MAX_DIGITS];
  logic [rdc_pkg::DIG_W-1:0] dig   [rdc_pkg::MAX_DIGITS];

  for (genvar i = 0; i < rdc_pkg::MAX_DIGITS; i++) begin : g_cell
    if (i == 0) begin : g_first
      rdc_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .base      (base),
        .tok_in    (ctl.feed),
        .cin       (feed_bit),
        .dig_in    ('0),
        .tok_out_r (tok[i]),
        .cout_r    (carry[i]),
        .digit_r   (dig[i])
      );
    end else begin : g_rest
      rdc_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .base      (base),
        .tok_in    (tok[i-1]),
        .cin       (carry[i-1]),
        .dig_in    (dig[i-1]),
        .tok_out_r (tok[i]),
        .cout_r    (carry[i]),
        .digit_r   (dig[i])
      );
    end
  end

  assign top_digit = dig[rdc_pkg::MAX_DIGITS-1];

endmodule
`default_nettype wire

FILE: hdl/radix_digit_converter_unit.sv
// top level: control sequencer, digit readout and output register
// a valid item goes through skewed bit-serial accumulation, then the digit cells are scanned
// a cell a cycle with leading zeros skipped, each other digit waiting while the output is stalled;
// an invalid base loads its single result from the invalid-base state once the output is free
// one item at a time: no new item is accepted until its last result is loaded
// reset clears the sequencer, the output valid flag and the cell tokens
`default_nettype none
module radix_digit_converter_unit (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [rdc_pkg::NUMBER_BITS-1:0]    in_number,
  input  wire logic [rdc_pkg::BASE_W-1:0]         in_base,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [rdc_pkg::CHAR_W-1:0]              out_digit_char,
  output logic                                    out_last,
  output logic                                    out_invalid_base
);

  rdc_pkg::state_t                  state_r, state_nxt;
  logic [rdc_pkg::NUMBER_BITS-1:0]  num_r, num_nxt;
  logic [rdc_pkg::BASE_W-1:0]       base_r, base_nxt;
  logic [rdc_pkg::CYC_W-1:0]        cyc_r, cyc_nxt;
  logic [rdc_pkg::CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                             started_r, started_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [rdc_pkg::CHAR_W-1:0]       out_char_r, out_char_nxt;
  logic                             out_last_r, out_last_nxt;
  logic                             out_inv_r, out_inv_nxt;
  rdc_pkg::array_ctl_t              ctl;
  logic [rdc_pkg::DIG_W-1:0]        top_digit;
  logic                             out_free;
  logic                             base_ok;

  assign out_free = !out_valid_r || out_ready;
  assign base_ok  = (in_base >= rdc_pkg::BASE_MIN) && (in_base <= rdc_pkg::BASE_MAX);

  rdc_digit_array u_array (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .base      (base_r),
    .feed_bit  (num_r[rdc_pkg::NUMBER_BITS-1]),
    .top_digit (top_digit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rdc_pkg::ST_IDLE;
      cyc_r       <= '0;
      cnt_r       <= '0;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cyc_r       <= cyc_nxt;
      cnt_r       <= cnt_nxt;
      started_r   <= started_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r      <= num_nxt;
    base_r     <= base_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    out_inv_r  <= out_inv_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    num_nxt       = num_r;
    base_nxt      = base_r;
    cyc_nxt       = cyc_r;
    cnt_nxt       = cnt_r;
    started_nxt   = started_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_inv_nxt   = out_inv_r;
    ctl           = '0;
    in_ready      = 1'b0;
    case (state_r)
      rdc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          num_nxt  = in_number;
          base_nxt = in_base;
          cyc_nxt  = '0;
          if (base_ok) begin
            ctl.clear = 1'b1;
            state_nxt = rdc_pkg::ST_CONV;
          end else begin
            state_nxt = rdc_pkg::ST_INV;
          end
        end
      end
      rdc_pkg::ST_CONV: begin
        // msb first into cell zero, carries ripple one cell per cycle
        ctl.feed = (cyc_r < rdc_pkg::CYC_W'(rdc_pkg::NUMBER_BITS));
        if (ctl.feed) begin
          num_nxt = {num_r[rdc_pkg::NUMBER_BITS-2:0], 1'b0};
        end
        cyc_nxt = cyc_r + 1'b1;
        if (cyc_r == rdc_pkg::CONV_DONE) begin
          cnt_nxt     = rdc_pkg::CNT_W'(rdc_pkg::MAX_DIGITS);
          started_nxt = 1'b0;
          state_nxt   = rdc_pkg::ST_EMIT;
        end
      end
      rdc_pkg::ST_EMIT: begin
        if (!started_r && (top_digit == '0) && (cnt_r > rdc_pkg::CNT_W'(1))) begin
          // leading zero
          ctl.shift = 1'b1;
          cnt_nxt   = cnt_r - 1'b1;
        end else if (out_free) begin
          ctl.shift     = 1'b1;
          cnt_nxt       = cnt_r - 1'b1;
          started_nxt   = 1'b1;
          out_valid_nxt = 1'b1;
          out_char_nxt  = rdc_pkg::ascii_of(top_digit);
          out_last_nxt  = (cnt_r == rdc_pkg::CNT_W'(1));
          out_inv_nxt   = 1'b0;
          if (cnt_r == rdc_pkg::CNT_W'(1)) begin
            state_nxt = rdc_pkg::ST_IDLE;
          end
        end
      end
      rdc_pkg::ST_INV: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = '0;
          out_last_nxt  = 1'b1;
          out_inv_nxt   = 1'b1;
          state_nxt     = rdc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rdc_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_digit_char   = out_char_r;
  assign out_last         = out_last_r;
  assign out_invalid_base = out_inv_r;

  a_inv_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_invalid_base |-> out_last && (out_digit_char == '0))
    else $error("invalid base transaction not a single zero result");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted during conversion");

  a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rdc_pkg::ST_EMIT |-> cnt_r != '0)
    else $error("digit readout ran past the last cell");

  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r ##1 out_valid_r && out_last_r |-> state_r == rdc_pkg::ST_IDLE)
    else $error("last digit loaded while conversion still active");

endmodule
`default_nettype wire
